/* rtl/fullwidth_fold_strip_lowercase_top_macros.svh */
// ----------------------------------------------------------------------------
// fullwidth fold normalizer assertion macros
// clocked assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef FULLWIDTH_FOLD_STRIP_LOWERCASE_TOP_MACROS_SVH
`define FULLWIDTH_FOLD_STRIP_LOWERCASE_TOP_MACROS_SVH

// assertion sampled on clk, disabled while reset is asserted
`define FFSL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// assertion sampled on clk that also holds during reset
`define FFSL_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ffsl_pkg.sv */
// ----------------------------------------------------------------------------
// ffsl_pkg
// shared types and constants of the fullwidth fold normalizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffsl_pkg;

	localparam int MAX_RES    = 4;
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0]  LEAD_SPACE = 8'hE3;
	localparam logic [7:0]  CONT_SPACE = 8'h80;
	localparam logic [7:0]  LEAD_WIDE  = 8'hEF;
	localparam logic [15:0] WIDE_LO    = 16'hBC81;
	localparam logic [15:0] WIDE_HI    = 16'hBD9E;
	localparam logic [7:0]  ASCII_SP   = 8'h20;
	localparam logic [7:0]  ASCII_TAB  = 8'h09;
	localparam logic [7:0]  ASCII_LF   = 8'h0A;
	localparam logic [7:0]  ASCII_CR   = 8'h0D;
	localparam logic [7:0]  UPPER_A    = 8'h41;
	localparam logic [7:0]  UPPER_Z    = 8'h5A;
	localparam logic [7:0]  CASE_OFS   = 8'h20;

	typedef struct packed {
		logic [7:0] data;
		logic       term;
		logic       last;
	} ffsl_item_t;

	typedef struct packed {
		ffsl_item_t [MAX_RES-1:0] items;
		logic [2:0]               count;
		logic [7:0]               held0;
		logic [7:0]               held1;
		logic [1:0]               held_cnt;
	} ffsl_result_t;

endpackage

`default_nettype wire

/* rtl/ffsl_core.sv */
// ----------------------------------------------------------------------------
// ffsl_core
// decodes the pending window plus one new byte into up to four result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffsl_core
	import ffsl_pkg::*;
(
	input  wire logic [7:0]   held0,
	input  wire logic [7:0]   held1,
	input  wire logic [1:0]   held_cnt,
	input  wire logic [7:0]   new_byte,
	input  wire logic         fin,
	output ffsl_result_t      res
);

	always_comb begin
		logic [7:0]  q [3];
		logic [1:0]  hc;
		logic [1:0]  len;
		logic [1:0]  pos;
		logic [1:0]  pos1;
		logic [1:0]  rem;
		logic [2:0]  n;
		logic        run;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [15:0] w;
		logic        lead;
		logic        full3;

		res = '0;
		hc  = (held_cnt == 2'd3) ? 2'd2 : held_cnt;
		q[0] = (hc == 2'd0) ? new_byte : held0;
		q[1] = (hc == 2'd1) ? new_byte : held1;
		q[2] = new_byte;
		len = hc + 2'd1;
		pos = 2'd0;
		n   = 3'd0;
		run = 1'b1;
		w   = {q[1], q[2]};
		rem   = 2'd0;
		b     = 8'h00;
		c     = 8'h00;
		lead  = 1'b0;
		full3 = 1'b0;

		// at most three window positions, one decision each
		for (int k = 0; k < 3; k++) begin
			if (run && pos < len) begin
				rem   = len - pos;
				b     = q[pos];
				c     = b;
				lead  = (b == LEAD_SPACE) || (b == LEAD_WIDE);
				full3 = (rem == 2'd3);
				if (lead && !full3 && !fin) begin
					run = 1'b0;
				end else if (full3 && b == LEAD_SPACE && q[1] == CONT_SPACE &&
						q[2] == CONT_SPACE) begin
					pos = 2'd3;
				end else begin
					if (full3 && b == LEAD_WIDE && w >= WIDE_LO && w <= WIDE_HI) begin
						c   = ASCII_SP + {1'b0, q[1][0], 6'b0} + {2'b0, q[2][5:0]};
						pos = 2'd3;
					end else begin
						pos = pos + 2'd1;
					end
					if (c != ASCII_SP && c != ASCII_TAB && c != ASCII_LF &&
							c != ASCII_CR) begin
						if (c >= UPPER_A && c <= UPPER_Z)
							c = c + CASE_OFS;
						res.items[n[1:0]].data = c;
						n = n + 3'd1;
					end
				end
			end
		end

		// leftover bytes stay pending unless the string ends here
		rem  = len - pos;
		pos1 = pos + 2'd1;
		if (fin) begin
			res.items[n[1:0]].term = 1'b1;
			n = n + 3'd1;
		end else begin
			res.held_cnt = rem;
			res.held0    = (rem != 2'd0 && pos != 2'd3) ? q[pos] : 8'h00;
			res.held1    = (rem == 2'd2 && pos1 != 2'd3) ? q[pos1] : 8'h00;
		end
		if (n != 3'd0)
			res.items[2'(n - 3'd1)].last = 1'b1;
		res.count = n;
	end

endmodule

`default_nettype wire

/* rtl/fullwidth_fold_strip_lowercase_top.sv */
// ----------------------------------------------------------------------------
// fullwidth_fold_strip_lowercase_top
// utf-8 fullwidth fold, whitespace strip and lowercase normalizer
// ----------------------------------------------------------------------------
// path: an accepted byte is registered in the input stage, then committed to the result queue that drives the output
// throughput: one input byte per cycle, one result per cycle on the output while out_ready is high;
//   input stalls only while the 8-entry result queue has fewer than 4 free slots
// reset: arst_n clears the input stage valid, pending window and queue pointers
`timescale 1ns / 1ps
`default_nettype none

module fullwidth_fold_strip_lowercase_top
	import ffsl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       final_byte,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] out_byte,
	output      logic       is_terminator,
	output      logic       run_last
);

	// input register stage
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// pending window of up to two bytes (lead bytes waiting for their tail)
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic [1:0] held_cnt_q;

	// result queue, one transaction leaves per cycle while out_ready is high
	ffsl_item_t       fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	ffsl_result_t     res;
	logic             space;
	logic             fire;
	logic             pop;
	logic [PTR_W-1:0] wr_idx [MAX_RES];

	ffsl_core u_core (
		.held0    (held0_q),
		.held1    (held1_q),
		.held_cnt (held_cnt_q),
		.new_byte (byte_s1),
		.fin      (fin_s1),
		.res      (res)
	);

	// a staged byte commits only when its worst-case burst fits in the queue
	assign space    = cnt_q <= CNT_W'(FIFO_DEPTH - MAX_RES);
	assign fire     = vld_s1 && space;
	assign in_ready = !vld_s1 || fire;

	assign out_valid     = cnt_q != '0;
	assign pop           = out_valid && out_ready;
	assign out_byte      = fifo_q[rd_ptr_q].data;
	assign is_terminator = fifo_q[rd_ptr_q].term;
	assign run_last      = fifo_q[rd_ptr_q].last;

	always_comb begin
		for (int i = 0; i < MAX_RES; i++)
			wr_idx[i] = wr_ptr_q + PTR_W'(i);
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			fin_s1  <= final_byte;
		end
	end

	// pending window follows each committed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held0_q    <= 8'h00;
			held1_q    <= 8'h00;
			held_cnt_q <= 2'd0;
		end else if (fire) begin
			held0_q    <= res.held0;
			held1_q    <= res.held1;
			held_cnt_q <= res.held_cnt;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fire)
				wr_ptr_q <= wr_ptr_q + PTR_W'(res.count);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + (fire ? CNT_W'(res.count) : '0) - CNT_W'(pop);
		end
	end

	// queue entries, a burst of up to four written at once
	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < MAX_RES; i++) begin
				if (3'(i) < res.count)
					fifo_q[wr_idx[i]] <= res.items[i];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/ffsl_checker.sv */
// ----------------------------------------------------------------------------
// ffsl_checker
// port-level checks of the normalizer output stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fullwidth_fold_strip_lowercase_top_macros.svh"

module ffsl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] in_byte,
	input wire logic       final_byte,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       is_terminator,
	input wire logic       run_last
);

	logic in_seen;
	assign in_seen = in_valid && in_ready && (in_byte == in_byte) && (final_byte == final_byte);

	// a stalled result holds its payload
	`FFSL_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_terminator) && $stable(run_last), "stalled result changed")

	// terminator carries a zero byte and closes its run
	`FFSL_ASSERT(a_term_form, clk, arst_n, out_valid && is_terminator |-> out_byte == 8'h00 && run_last, "malformed terminator")

	// data results never carry whitespace or upper case
	`FFSL_ASSERT(a_data_clean, clk, arst_n, out_valid && !is_terminator |-> out_byte != 8'h20 && out_byte != 8'h09 && out_byte != 8'h0A && out_byte != 8'h0D && (out_byte < 8'h41 || out_byte > 8'h5A), "unnormalized byte emitted")

	// while reset stays asserted, no result is offered unless an input transaction is seen
	`FFSL_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !out_valid || in_seen || arst_n, "output valid out of reset")

endmodule

bind fullwidth_fold_strip_lowercase_top ffsl_checker u_ffsl_checker (.*);

`default_nettype wire
